// ===== sv/assert_macros.svh =====
// Assertion macros shared by the keyed list table RTL.
// No dependencies; the macro bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define BKL_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: %m");
`define BKL_ASSERT_NEXT(name, clk, rst_n, trig, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed: %m");
`else
`define BKL_ASSERT(name, clk, rst_n, prop)
`define BKL_ASSERT_NEXT(name, clk, rst_n, trig, cons)
`endif

`endif

// ===== sv/bkl_pkg.sv =====
// Types and codes for the keyed list table: ops, status, probe beat, update.
// No dependencies.
package bkl_pkg;

    typedef logic [8:0] t_wide;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_READ   = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        UPD_NONE  = 2'd0,
        UPD_WRITE = 2'd1,
        UPD_SHIFT = 2'd2
    } t_upd_kind;

    // probe beat walking the cell chain
    typedef struct packed {
        logic        valid;
        t_op         op;
        logic [31:0] key;
        logic [3:0]  pos;
        logic        hit;
        logic [3:0]  hit_pos;
        logic [31:0] hit_key;
        logic [31:0] hit_payload;
        logic [31:0] last_key;
        logic [31:0] last_payload;
    } t_beat;

    // entry update broadcast to every cell
    typedef struct packed {
        t_upd_kind   kind;
        t_wide       idx;
        t_wide       lim;
        logic [31:0] key;
        logic [31:0] payload;
    } t_upd;

endpackage

// ===== sv/bounded_keyed_list_table.sv =====
// Bounded keyed list table: up to DEPTH (key, payload) entries packed from position 1.
// An insert, or a read or remove with a bad position, goes from accept to S_EMIT and
// back to S_IDLE. A find, read or remove first sends a probe beat through the row of
// DEPTH cells, one cell a cycle, in S_WALK. The result sits in an output register,
// so the next item is accepted while it waits. remove_mode sits at byte address 0
// of the APB port. Depends on bkl_pkg, bkl_cell and assert_macros.svh.
`include "assert_macros.svh"

module bounded_keyed_list_table #(
    parameter int DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_key,
    input  logic [31:0]        i_payload,
    input  logic [3:0]         i_position,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic [3:0]         o_found_position,
    output logic signed [31:0] o_entry_key,
    output logic [31:0]        o_entry_payload,
    output logic [3:0]         o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_EMIT} t_state;

    typedef struct packed {
        bkl_pkg::t_status status;
        logic [3:0]       pos;
        logic [31:0]      key;
        logic [31:0]      payload;
        logic [3:0]       count;
    } t_result;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_mode, n_mode;
    t_result         r_res, n_res;
    t_result         r_out, n_out;
    logic            r_out_valid, n_out_valid;

    bkl_pkg::t_beat  w_beat [DEPTH+1];
    logic [31:0]     w_key [DEPTH+1];
    logic [31:0]     w_payload [DEPTH+1];
    logic [DEPTH-1:0] beat_vld;
    bkl_pkg::t_upd   upd;
    bkl_pkg::t_beat  head;
    bkl_pkg::t_beat  tail;
    bkl_pkg::t_op    op;
    bkl_pkg::t_wide  cnt_w, pos_w, inc_w, dec_w, gap_w;
    logic            acc_in, full, bad_pos, cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && !paddr[2];
    assign prdata  = paddr[2] ? 32'd0 : {31'd0, r_mode};
    assign o_ready = (r_state == S_IDLE);
    assign acc_in  = i_valid && o_ready;
    assign op      = bkl_pkg::t_op'(i_op);
    assign cnt_w   = bkl_pkg::t_wide'(r_count);
    assign pos_w   = bkl_pkg::t_wide'(i_position);
    assign inc_w   = cnt_w + 9'd1;
    assign dec_w   = cnt_w - 9'd1;
    assign full    = cnt_w >= bkl_pkg::t_wide'(DEPTH);
    assign bad_pos = (pos_w == 9'd0) || (pos_w > cnt_w);
    assign tail    = w_beat[DEPTH];
    assign gap_w   = bkl_pkg::t_wide'(tail.pos) - 9'd1;

    always_comb begin
        head         = '0;
        head.valid   = acc_in && (op == bkl_pkg::OP_FIND
                       || ((op == bkl_pkg::OP_READ || op == bkl_pkg::OP_REMOVE)
                           && !bad_pos));
        head.op      = op;
        head.key     = i_key;
        head.pos     = i_position;
    end

    assign w_beat[0]        = head;
    assign w_key[DEPTH]     = '0;
    assign w_payload[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bkl_cell #(.INDEX(g)) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_beat         (w_beat[g]),
            .o_beat         (w_beat[g+1]),
            .i_count        (cnt_w),
            .i_upd          (upd),
            .i_next_key     (w_key[g+1]),
            .i_next_payload (w_payload[g+1]),
            .o_key          (w_key[g]),
            .o_payload      (w_payload[g])
        );
        assign beat_vld[g] = w_beat[g+1].valid;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_mode      = cfg_wr ? pwdata[0] : r_mode;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        upd         = '0;
        upd.kind    = bkl_pkg::UPD_NONE;

        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    n_state = S_EMIT;
                    n_res   = '0;
                    n_res.count = cnt_w[3:0];
                    case (op)
                        bkl_pkg::OP_INSERT: begin
                            if (full) begin
                                n_res.status = bkl_pkg::ST_FULL;
                            end else begin
                                upd.kind      = bkl_pkg::UPD_WRITE;
                                upd.idx       = cnt_w;
                                upd.key       = i_key;
                                upd.payload   = i_payload;
                                n_count       = r_count + CW'(1);
                                n_res.status  = bkl_pkg::ST_OK;
                                n_res.pos     = inc_w[3:0];
                                n_res.key     = i_key;
                                n_res.payload = i_payload;
                                n_res.count   = inc_w[3:0];
                            end
                        end
                        bkl_pkg::OP_FIND: begin
                            n_state = S_WALK;
                        end
                        default: begin
                            if (bad_pos) begin
                                n_res.status = bkl_pkg::ST_BAD_POS;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (tail.valid) begin
                    n_state       = S_EMIT;
                    n_res.status  = bkl_pkg::ST_OK;
                    n_res.pos     = tail.hit_pos;
                    n_res.key     = tail.hit_key;
                    n_res.payload = tail.hit_payload;
                    n_res.count   = cnt_w[3:0];
                    if (tail.op == bkl_pkg::OP_FIND && !tail.hit) begin
                        n_res        = '0;
                        n_res.status = bkl_pkg::ST_NOT_FOUND;
                        n_res.count  = cnt_w[3:0];
                    end
                    if (tail.op == bkl_pkg::OP_REMOVE) begin
                        n_count     = r_count - CW'(1);
                        n_res.count = dec_w[3:0];
                        upd.idx     = gap_w;
                        upd.lim     = dec_w;
                        upd.key     = tail.last_key;
                        upd.payload = tail.last_payload;
                        upd.kind    = r_mode ? bkl_pkg::UPD_SHIFT : bkl_pkg::UPD_WRITE;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
            r_res       <= n_res;
            r_out       <= n_out;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found_position = r_out.pos;
    assign o_entry_key      = r_out.key;
    assign o_entry_payload  = r_out.payload;
    assign o_entry_count    = r_out.count;

    `BKL_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `BKL_ASSERT(a_one_probe, i_clk, i_rst_n, $onehot0(beat_vld))
    `BKL_ASSERT(a_tail_in_walk, i_clk, i_rst_n, tail.valid |-> r_state == S_WALK)
    `BKL_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, acc_in && op == bkl_pkg::OP_INSERT && !full, r_count == $past(r_count) + CW'(1))
    `BKL_ASSERT_NEXT(a_remove_count, i_clk, i_rst_n, r_state == S_WALK && tail.valid && tail.op == bkl_pkg::OP_REMOVE, r_count == $past(r_count) - CW'(1))

endmodule

// ===== sv/bkl_cell.sv =====
// One table cell: holds one entry and one stage of the probe chain.
// Depends on bkl_pkg.
module bkl_cell #(
    parameter int INDEX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bkl_pkg::t_beat       i_beat,
    output bkl_pkg::t_beat       o_beat,
    input  bkl_pkg::t_wide       i_count,
    input  bkl_pkg::t_upd        i_upd,
    input  logic [31:0]          i_next_key,
    input  logic [31:0]          i_next_payload,
    output logic [31:0]          o_key,
    output logic [31:0]          o_payload
);

    localparam bkl_pkg::t_wide IDX  = bkl_pkg::t_wide'(INDEX);
    localparam bkl_pkg::t_wide POS1 = bkl_pkg::t_wide'(INDEX + 1);

    logic [31:0]    r_key;
    logic [31:0]    r_payload;
    bkl_pkg::t_beat r_beat;
    bkl_pkg::t_beat n_beat;
    logic           in_range;
    logic           is_match;

    always_comb begin
        in_range = IDX < i_count;
        if (i_beat.op == bkl_pkg::OP_FIND) begin
            is_match = i_beat.valid && !i_beat.hit && in_range && (i_beat.key == r_key);
        end else begin
            is_match = i_beat.valid && !i_beat.hit && in_range
                       && ({5'd0, i_beat.pos} == POS1);
        end
        n_beat = i_beat;
        if (is_match) begin
            n_beat.hit         = 1'b1;
            n_beat.hit_pos     = POS1[3:0];
            n_beat.hit_key     = r_key;
            n_beat.hit_payload = r_payload;
        end
        if (i_beat.valid && (POS1 == i_count)) begin
            n_beat.last_key     = r_key;
            n_beat.last_payload = r_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.kind == bkl_pkg::UPD_WRITE && i_upd.idx == IDX) begin
            r_key     <= i_upd.key;
            r_payload <= i_upd.payload;
        end else if (i_upd.kind == bkl_pkg::UPD_SHIFT && IDX >= i_upd.idx
                     && IDX < i_upd.lim) begin
            r_key     <= i_next_key;
            r_payload <= i_next_payload;
        end
    end

    assign o_beat    = r_beat;
    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule

// ===== tb/bkl_result_checker.sv =====
// Result checker for the keyed list table: snoops the APB port and both channels.
// Keeps its own copy of the table, predicts each result and compares it field by field.
// Depends on bkl_pkg.
module bkl_result_checker
    import bkl_pkg::*;
#(
    parameter int         DEPTH     = 8,
    parameter logic [2:0] MODE_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_key,
    input  logic [31:0] i_payload,
    input  logic [3:0]  i_position,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [3:0]  i_found_position,
    input  logic [31:0] i_entry_key,
    input  logic [31:0] i_entry_payload,
    input  logic [3:0]  i_entry_count,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        t_status     status;
        logic [3:0]  pos;
        logic [31:0] key;
        logic [31:0] payload;
        logic [3:0]  count;
    } t_table_result;

    logic [31:0]   tbl_key [DEPTH];
    logic [31:0]   tbl_payload [DEPTH];
    int            held;
    logic          shift_mode;
    t_table_result pending_results[$];
    int            fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: mismatch on %s: expected %0h, got %0h", $time, field, want, got);
        fail_cnt++;
    endtask

    // applies one operation to the table copy and returns the result it gives
    task automatic apply_table_op(input t_op op, input logic [31:0] key,
                                  input logic [31:0] payload, input logic [3:0] pos,
                                  output t_table_result res);
        int  idx;
        int  last;
        bit  hit;
        res        = '0;
        res.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (held >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    tbl_key[held]     = key;
                    tbl_payload[held] = payload;
                    held++;
                    res.pos     = 4'(held);
                    res.key     = key;
                    res.payload = payload;
                end
            end
            OP_FIND: begin
                hit = 1'b0;
                for (int i = 0; i < held; i++) begin
                    if (!hit && tbl_key[i] == key) begin
                        hit         = 1'b1;
                        res.pos     = 4'(i + 1);
                        res.key     = tbl_key[i];
                        res.payload = tbl_payload[i];
                    end
                end
                if (!hit) res.status = ST_NOT_FOUND;
            end
            default: begin
                if (pos == 0 || int'(pos) > held) begin
                    res.status = ST_BAD_POS;
                end else begin
                    idx         = int'(pos) - 1;
                    res.pos     = pos;
                    res.key     = tbl_key[idx];
                    res.payload = tbl_payload[idx];
                    if (op == OP_REMOVE) begin
                        last = held - 1;
                        if (!shift_mode) begin
                            tbl_key[idx]     = tbl_key[last];
                            tbl_payload[idx] = tbl_payload[last];
                        end else begin
                            for (int i = idx; i < last; i++) begin
                                tbl_key[i]     = tbl_key[i + 1];
                                tbl_payload[i] = tbl_payload[i + 1];
                            end
                        end
                        held = last;
                    end
                end
            end
        endcase
        res.count = 4'(held);
    endtask

    always @(posedge i_clk) begin
        t_table_result want;
        t_table_result got;
        if (!i_rst_n) begin
            held       = 0;
            shift_mode = 1'b0;
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{t_status'(i_status), i_found_position, i_entry_key,
                        i_entry_payload, i_entry_count};
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result status", '0, 32'(got.status));
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 32'(want.status), 32'(got.status));
                    if (got.pos != want.pos)
                        report_mismatch("found_position", 32'(want.pos), 32'(got.pos));
                    if (got.key != want.key)
                        report_mismatch("entry_key", want.key, got.key);
                    if (got.payload != want.payload)
                        report_mismatch("entry_payload", want.payload, got.payload);
                    if (got.count != want.count)
                        report_mismatch("entry_count", 32'(want.count), 32'(got.count));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == MODE_ADDR)
                shift_mode = i_pwdata[0];
            if (i_in_valid && i_in_ready) begin
                apply_table_op(t_op'(i_op), i_key, i_payload, i_position, want);
                pending_results.push_back(want);
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

// ===== tb/tb_bounded_keyed_list_table.sv =====
// Top of the keyed list table testbench: clock, reset, APB writes and item stimulus.
// Depends on bkl_pkg, bounded_keyed_list_table and bkl_result_checker.
module tb_bounded_keyed_list_table;
    import bkl_pkg::*;

    localparam int         DEPTH           = 8;
    localparam logic [2:0] REG_REMOVE_MODE = 3'd0;
    localparam int         ITEMS_PER_PHASE = 150;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid    = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op       = '0;
    logic [31:0] i_key      = '0;
    logic [31:0] i_payload  = '0;
    logic [3:0]  i_position = '0;
    logic        o_valid;
    logic        i_ready    = 1'b0;
    logic [1:0]  o_status;
    logic [3:0]  o_found_position;
    logic [31:0] o_entry_key;
    logic [31:0] o_entry_payload;
    logic [3:0]  o_entry_count;

    int          snd_idle_pct = 16;
    int          rcv_idle_pct = 50;
    int          fail_count;
    int          pending;
    logic [31:0] key_pool [4];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    bounded_keyed_list_table #(.DEPTH(DEPTH)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_key           (i_key),
        .i_payload       (i_payload),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_found_position(o_found_position),
        .o_entry_key     (o_entry_key),
        .o_entry_payload (o_entry_payload),
        .o_entry_count   (o_entry_count)
    );

    bkl_result_checker #(.DEPTH(DEPTH), .MODE_ADDR(REG_REMOVE_MODE)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_op            (i_op),
        .i_key           (i_key),
        .i_payload       (i_payload),
        .i_position      (i_position),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_status        (o_status),
        .i_found_position(o_found_position),
        .i_entry_key     (o_entry_key),
        .i_entry_payload (o_entry_payload),
        .i_entry_count   (o_entry_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    task automatic send_item(input t_op op, input logic [31:0] key,
                             input logic [31:0] payload, input logic [3:0] pos);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_key      <= key;
        i_payload  <= payload;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // lowers valid, lets every outstanding beat drain, then allows for the probe walk
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic write_remove_mode(input logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_REMOVE_MODE;
        pwdata  <= {31'd0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // alternates fill-heavy and drain-heavy stretches so the table runs full and empty
    task automatic random_item(input int n);
        t_op         op;
        logic [31:0] key;
        logic [3:0]  pos;
        int          pick;
        int          ins_w;
        pick  = $urandom_range(99);
        ins_w = ((n / 24) % 2 == 0) ? 50 : 15;
        if (pick < ins_w)           op = OP_INSERT;
        else if (pick < ins_w + 20) op = OP_FIND;
        else if (pick < ins_w + 40) op = OP_READ;
        else                        op = OP_REMOVE;
        if ($urandom_range(99) < 65) begin
            key = key_pool[$urandom_range(3)];
        end else begin
            key = $urandom;
            if (op == OP_INSERT && $urandom_range(3) == 0) key_pool[$urandom_range(3)] = key;
        end
        if ($urandom_range(9) < 8) pos = 4'($urandom_range(DEPTH, 1));
        else                       pos = 4'($urandom_range(15));
        send_item(op, key, $urandom, pos);
    endtask

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = $urandom;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_remove_mode(1'b0);

        // empty table, then fill to the brim with extreme keys and a duplicate
        send_item(OP_READ,   32'd0, 32'd0, 4'd1);
        send_item(OP_REMOVE, 32'd0, 32'd0, 4'd0);
        send_item(OP_FIND,   32'd0, 32'd0, 4'd0);
        send_item(OP_INSERT, 32'h8000_0000, 32'h0000_0000, 4'd0);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        send_item(OP_INSERT, 32'h0000_0000, 32'h5555_5555, 4'd0);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 4'd0);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0001, 4'd0);
        send_item(OP_INSERT, 32'd5, 32'd50, 4'd0);
        send_item(OP_INSERT, 32'd6, 32'd60, 4'd0);
        send_item(OP_INSERT, 32'd7, 32'd70, 4'd0);
        send_item(OP_INSERT, 32'd8, 32'd80, 4'd0);
        send_item(OP_FIND,   32'h7FFF_FFFF, 32'd0, 4'd0);
        send_item(OP_FIND,   32'd12345, 32'd0, 4'd0);
        send_item(OP_READ,   32'd0, 32'd0, 4'd0);
        send_item(OP_READ,   32'd0, 32'd0, 4'd8);
        send_item(OP_READ,   32'd0, 32'd0, 4'd15);
        send_item(OP_REMOVE, 32'd0, 32'd0, 4'd9);
        send_item(OP_REMOVE, 32'd0, 32'd0, 4'd2);
        wait_drained();
        write_remove_mode(1'b1);
        send_item(OP_REMOVE, 32'd0, 32'd0, 4'd1);
        send_item(OP_FIND,   32'h7FFF_FFFF, 32'd0, 4'd0);
        send_item(OP_READ,   32'd0, 32'd0, 4'd7);
        send_item(OP_REMOVE, 32'd0, 32'd0, 4'd6);

        for (int p = 0; p < 3; p++) begin
            wait_drained();
            case (p)
                0: begin
                    snd_idle_pct = 16;
                    rcv_idle_pct = 50;
                    write_remove_mode(1'b0);
                end
                1: begin
                    snd_idle_pct = 50;
                    rcv_idle_pct = 16;
                    write_remove_mode(1'b1);
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    write_remove_mode(1'($urandom_range(1)));
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item(n);
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
